// ===== hdl/rgba_window_average_defines.svh =====
// Assertion helpers used by rgba_window_average.
`ifndef RGBA_WINDOW_AVERAGE_DEFINES_SVH
`define RGBA_WINDOW_AVERAGE_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define RWA_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent one cycle, consequent on the next edge.
`define RWA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/rwa_pkg.sv =====
package rwa_pkg;

	// Window and channel geometry
	localparam int WINDOW_DEPTH = 8;
	localparam int NUM_CH       = 4;
	localparam int DATA_W       = 8;
	localparam int SLOT_W       = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int COUNT_W      = $clog2(WINDOW_DEPTH + 1);
	localparam int SUM_W        = DATA_W + COUNT_W;
	localparam int WORD_W       = NUM_CH * DATA_W;
	localparam int STEP_W       = $clog2(DATA_W);

	typedef struct packed {
		logic [DATA_W-1:0] red_in;
		logic [DATA_W-1:0] green_in;
		logic [DATA_W-1:0] blue_in;
		logic [DATA_W-1:0] alpha_in;
	} rgba_in_t;

	typedef struct packed {
		logic [DATA_W-1:0] red_avg;
		logic [DATA_W-1:0] green_avg;
		logic [DATA_W-1:0] blue_avg;
		logic [DATA_W-1:0] alpha_avg;
	} rgba_out_t;

	// One lane per channel; red sits in the top lane
	typedef logic [NUM_CH-1:0][DATA_W-1:0] lane_word_t;
	typedef logic [NUM_CH-1:0][SUM_W-1:0]  lane_sum_t;

	typedef enum logic [2:0] {
		RWA_IDLE,
		RWA_SUM,
		RWA_LOAD,
		RWA_DIV,
		RWA_OUT
	} rwa_state_t;

	// Divider handshake with the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ===== hdl/rwa_ram.sv =====
module rwa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hdl/rwa_div.sv =====
module rwa_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  rwa_pkg::lane_sum_t           sum,
	input  logic [rwa_pkg::COUNT_W-1:0]  divisor,
	output rwa_pkg::div_stat_t           stat,
	output rwa_pkg::lane_word_t          quo
);

	logic                          busy_q;
	logic [rwa_pkg::STEP_W-1:0]    step_q;
	logic [rwa_pkg::COUNT_W-1:0]   div_q;
	logic [rwa_pkg::COUNT_W-1:0]   rem_q [rwa_pkg::NUM_CH];
	rwa_pkg::lane_word_t           lo_q;
	logic [rwa_pkg::COUNT_W-1:0]   rem_nxt [rwa_pkg::NUM_CH];
	logic [rwa_pkg::NUM_CH-1:0]    qbit;
	logic                          last_step;

	// Quotient fits the data width, so the high sum bits seed the remainder
	// and only DATA_W restoring steps are needed.
	assign last_step = (step_q == rwa_pkg::STEP_W'(rwa_pkg::DATA_W - 1));

	// One restoring step per lane
	always_comb begin
		logic [rwa_pkg::COUNT_W:0] sh;
		for (int c = 0; c < rwa_pkg::NUM_CH; c++) begin
			sh = {rem_q[c], lo_q[c][rwa_pkg::DATA_W-1]};
			if (sh >= {1'b0, div_q}) begin
				qbit[c]    = 1'b1;
				rem_nxt[c] = rwa_pkg::COUNT_W'(sh - {1'b0, div_q});
			end else begin
				qbit[c]    = 1'b0;
				rem_nxt[c] = rwa_pkg::COUNT_W'(sh);
			end
		end
	end

	// Step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			busy_q <= !last_step;
			step_q <= step_q + rwa_pkg::STEP_W'(1);
		end
	end

	// Remainder and dividend/quotient shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= divisor;
			for (int c = 0; c < rwa_pkg::NUM_CH; c++) begin
				rem_q[c] <= sum[c][rwa_pkg::SUM_W-1:rwa_pkg::DATA_W];
				lo_q[c]  <= sum[c][rwa_pkg::DATA_W-1:0];
			end
		end else if (busy_q) begin
			for (int c = 0; c < rwa_pkg::NUM_CH; c++) begin
				rem_q[c] <= rem_nxt[c];
				lo_q[c]  <= {lo_q[c][rwa_pkg::DATA_W-2:0], qbit[c]};
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = busy_q && last_step;
	assign quo       = lo_q;

endmodule

// ===== hdl/rgba_window_average.sv =====
// RGBA moving average with warm-up. Each accepted sample is stored in an
// 8-entry circular history and one result word follows: per channel, the
// truncated mean of the samples stored so far (up to the last 8). The
// history is summed one entry per cycle from a two-port RAM, then a
// shared restoring divider produces all four quotients one bit per cycle.
// The result word follows the history read loop and the 8 divider steps.
// The next sample is accepted no earlier than the cycle after the result
// word is taken, so a new sample is not taken while one is in progress.
// The history RAM needs no clearing after reset.
`include "rgba_window_average_defines.svh"

module rgba_window_average (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                sample_valid,
	output logic                sample_stall,
	input  rwa_pkg::rgba_in_t   sample,
	output logic                avg_valid,
	input  logic                avg_stall,
	output rwa_pkg::rgba_out_t  avg
);

	rwa_pkg::rwa_state_t            state_q, state_nxt;
	logic [rwa_pkg::SLOT_W-1:0]     slot_q;
	logic [rwa_pkg::COUNT_W-1:0]    count_q;
	logic [rwa_pkg::SLOT_W-1:0]     rd_idx_q;
	logic                           issue_done_q;
	logic                           rd_vld_s1;
	logic                           rd_last_s1;
	rwa_pkg::lane_sum_t             sum_q;
	rwa_pkg::lane_word_t            rd_data;
	rwa_pkg::lane_word_t            wr_data;
	rwa_pkg::lane_word_t            quo;
	rwa_pkg::div_stat_t             div_stat;
	logic                           accept;
	logic                           rd_issue;
	logic                           last_issue;
	logic                           div_start;

	assign accept     = sample_valid && !sample_stall;
	assign wr_data    = sample;
	assign last_issue = ((rwa_pkg::COUNT_W'(rd_idx_q) + rwa_pkg::COUNT_W'(1)) == count_q);

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			rwa_pkg::RWA_IDLE: if (sample_valid) state_nxt = rwa_pkg::RWA_SUM;
			rwa_pkg::RWA_SUM:  if (rd_vld_s1 && rd_last_s1) state_nxt = rwa_pkg::RWA_LOAD;
			rwa_pkg::RWA_LOAD: state_nxt = rwa_pkg::RWA_DIV;
			rwa_pkg::RWA_DIV:  if (div_stat.done) state_nxt = rwa_pkg::RWA_OUT;
			rwa_pkg::RWA_OUT:  if (!avg_stall) state_nxt = rwa_pkg::RWA_IDLE;
			default:           state_nxt = rwa_pkg::RWA_IDLE;
		endcase
	end

	// State-decoded controls
	always_comb begin
		sample_stall = 1'b1;
		avg_valid    = 1'b0;
		rd_issue     = 1'b0;
		div_start    = 1'b0;
		unique case (state_q)
			rwa_pkg::RWA_IDLE: sample_stall = 1'b0;
			rwa_pkg::RWA_SUM:  rd_issue = !issue_done_q;
			rwa_pkg::RWA_LOAD: div_start = 1'b1;
			rwa_pkg::RWA_DIV:  ;
			rwa_pkg::RWA_OUT:  avg_valid = 1'b1;
			default:           ;
		endcase
	end

	// Sequencer, slot and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= rwa_pkg::RWA_IDLE;
			slot_q       <= '0;
			count_q      <= '0;
			rd_idx_q     <= '0;
			issue_done_q <= 1'b0;
			rd_vld_s1    <= 1'b0;
			rd_last_s1   <= 1'b0;
		end else begin
			state_q    <= state_nxt;
			rd_vld_s1  <= rd_issue;
			rd_last_s1 <= last_issue;
			if (accept) begin
				slot_q <= (slot_q == rwa_pkg::SLOT_W'(rwa_pkg::WINDOW_DEPTH - 1)) ?
					'0 : slot_q + rwa_pkg::SLOT_W'(1);
				if (count_q != rwa_pkg::COUNT_W'(rwa_pkg::WINDOW_DEPTH)) begin
					count_q <= count_q + rwa_pkg::COUNT_W'(1);
				end
				rd_idx_q     <= '0;
				issue_done_q <= 1'b0;
			end else if (rd_issue) begin
				issue_done_q <= last_issue;
				if (!last_issue) begin
					rd_idx_q <= rd_idx_q + rwa_pkg::SLOT_W'(1);
				end
			end
		end
	end

	// Channel sums, one history entry per cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			sum_q <= '0;
		end else if (rd_vld_s1) begin
			for (int c = 0; c < rwa_pkg::NUM_CH; c++) begin
				sum_q[c] <= sum_q[c] + rwa_pkg::SUM_W'(rd_data[c]);
			end
		end
	end

	rwa_ram #(
		.WIDTH (rwa_pkg::WORD_W),
		.DEPTH (rwa_pkg::WINDOW_DEPTH)
	) u_hist (
		.clk   (clk),
		.we    (accept),
		.waddr (slot_q),
		.wdata (wr_data),
		.raddr (rd_idx_q),
		.rdata (rd_data)
	);

	rwa_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.sum     (sum_q),
		.divisor (count_q),
		.stat    (div_stat),
		.quo     (quo)
	);

	assign avg = quo;

	// Checks
	`RWA_ASSERT(a_count_range, state_q != rwa_pkg::RWA_IDLE, (count_q != '0) && (count_q <= rwa_pkg::COUNT_W'(rwa_pkg::WINDOW_DEPTH)), "fill count out of range while busy")
	`RWA_ASSERT_NEXT(a_accept_sum, accept, state_q == rwa_pkg::RWA_SUM, "accepted word did not start the sum")
	`RWA_ASSERT(a_div_done, div_stat.done, state_q == rwa_pkg::RWA_DIV, "divider finished outside the divide phase")

endmodule
